FILE: rtl/gisr_pkg.sv
// Shared types and constants for the glyph italic shear rasterizer.
package gisr_pkg;

	localparam int DIM_W = 7;
	localparam int COL_W = 8;
	localparam int VAL_W = 8;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_GLYPH_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_GLYPH_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_ITALIC_ENABLE = 2'd2;

	// Everything the column sequencer needs to emit the results of one item.
	typedef struct packed {
		logic [COL_W-1:0] first_col;
		logic [COL_W-1:0] end_col;
		logic [COL_W-1:0] main_col;
		logic [COL_W-1:0] carry_col;
		logic [COL_W-1:0] last_col;
		logic [VAL_W-1:0] main_val;
		logic [VAL_W-1:0] carry_val;
		logic             has_carry;
		logic [DIM_W-1:0] row;
		logic             last_row;
	} desc_t;

endpackage

FILE: rtl/gisr_front.sv
// Configuration registers, glyph position state and per-item shear arithmetic.
module gisr_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gisr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [gisr_pkg::DIM_W-1:0]   cfg_data,
	input  logic [gisr_pkg::VAL_W-1:0]   coverage,
	input  logic                         accept,
	output gisr_pkg::desc_t              desc
);

	localparam logic [6:0] WMAX = (MAX_WIDTH > 127) ? 7'd127 : 7'(MAX_WIDTH);
	localparam logic [6:0] HMAX = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);

	logic [6:0] glyph_width_q, glyph_height_q;
	logic       italic_q;
	logic [6:0] col_q, row_q;
	logic [7:0] carry_q;

	logic [6:0] w, h, row, x, s, extra;
	logic [4:0] q;
	logic [1:0] f;
	logic [2:0] wt_hi;
	logic [9:0] prod_hi, prod_lo;
	logic [7:0] carry_in, fw, main_col, carry_col;
	logic [8:0] sum;
	logic       tail, row_wrap;

	always_comb begin
		if (glyph_width_q == 7'd0) begin
			w = 7'd1;
		end else if (glyph_width_q > WMAX) begin
			w = WMAX;
		end else begin
			w = glyph_width_q;
		end
		if (glyph_height_q == 7'd0) begin
			h = 7'd1;
		end else if (glyph_height_q > HMAX) begin
			h = HMAX;
		end else begin
			h = glyph_height_q;
		end
		row = (row_q >= h) ? 7'd0 : row_q;
		x = (col_q >= w) ? 7'd0 : col_q;
		// Shear in quarter pixels: whole pixels in q, leftover quarter steps in f.
		s = italic_q ? (h - 7'd1 - row) : 7'd0;
		q = s[6:2];
		f = s[1:0];
		extra = italic_q ? {2'b00, h[6:2]} : 7'd0;
		fw = {1'b0, w} + {1'b0, extra};
		main_col = {1'b0, x} + {3'b000, q};
		carry_col = {1'b0, w} + {3'b000, q};
		wt_hi = 3'd4 - {1'b0, f};
		prod_hi = {2'b00, coverage} * {7'b0, wt_hi};
		prod_lo = {2'b00, coverage} * {8'b0, f};
		carry_in = (x == 7'd0) ? 8'd0 : carry_q;
		sum = {1'b0, prod_hi[9:2]} + {1'b0, carry_in};
		tail = (x == w - 7'd1);
		row_wrap = ({1'b0, row} + 8'd1 >= {1'b0, h});

		desc.first_col = (x == 7'd0) ? 8'd0 : main_col;
		desc.end_col = tail ? (fw - 8'd1) : main_col;
		desc.main_col = main_col;
		desc.carry_col = carry_col;
		desc.last_col = fw - 8'd1;
		desc.main_val = sum[8] ? 8'hFF : sum[7:0];
		desc.carry_val = prod_lo[9:2];
		desc.has_carry = tail;
		desc.row = row;
		desc.last_row = (row == h - 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q <= 7'd1;
			glyph_height_q <= 7'd1;
			italic_q <= 1'b0;
			col_q <= 7'd0;
			row_q <= 7'd0;
			carry_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				gisr_pkg::REG_GLYPH_WIDTH: begin
					glyph_width_q <= cfg_data;
				end
				gisr_pkg::REG_GLYPH_HEIGHT: begin
					glyph_height_q <= cfg_data;
				end
				gisr_pkg::REG_ITALIC_ENABLE: begin
					italic_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
			// Any write restarts the glyph at pixel 0 of row 0.
			col_q <= 7'd0;
			row_q <= 7'd0;
			carry_q <= 8'd0;
		end else if (accept) begin
			if (tail) begin
				col_q <= 7'd0;
				carry_q <= 8'd0;
				row_q <= row_wrap ? 7'd0 : row + 7'd1;
			end else begin
				col_q <= x + 7'd1;
				carry_q <= prod_lo[9:2];
				row_q <= row;
			end
		end
	end

endmodule

FILE: rtl/gisr_emit.sv
// Item register, destination column sequencer and result register.
module gisr_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gisr_pkg::desc_t              desc,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic                         accept,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gisr_pkg::VAL_W-1:0]   pixel_value,
	output logic [6:0]                   out_column,
	output logic [5:0]                   out_row,
	output logic                         row_end,
	output logic                         glyph_end
);

	gisr_pkg::desc_t              desc_s1;
	logic                         valid_s1;
	logic [gisr_pkg::COL_W-1:0]   cur_col_q;
	logic                         advance, done;
	logic [gisr_pkg::VAL_W-1:0]   val;
	logic                         rend;

	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign done = advance && (cur_col_q == desc_s1.end_col);
	assign in_stall = valid_s1 && !done;
	assign accept = in_valid && !in_stall;

	always_comb begin
		if (cur_col_q == desc_s1.main_col) begin
			val = desc_s1.main_val;
		end else if (desc_s1.has_carry && cur_col_q == desc_s1.carry_col) begin
			val = desc_s1.carry_val;
		end else begin
			val = '0;
		end
		rend = (cur_col_q == desc_s1.last_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
			cur_col_q <= desc.first_col;
		end else if (advance) begin
			cur_col_q <= cur_col_q + 8'd1;
		end
		if (advance) begin
			pixel_value <= val;
			out_column <= cur_col_q[6:0];
			out_row <= desc_s1.row[5:0];
			row_end <= rend;
			glyph_end <= rend && desc_s1.last_row;
		end
	end

endmodule

FILE: rtl/glyph_italic_shear_rasterizer.sv
// Top level of the glyph italic shear rasterizer.
// Coverage bytes of a glyph bitmap enter in row-major order on the input
// channel (in_valid, in_stall, coverage). Each item produces one or more
// destination pixels on the output channel (out_valid, out_stall,
// pixel_value, out_column, out_row, row_end, glyph_end). With italic set,
// the first pixel of a row also produces the zero columns in front of it,
// and the last pixel of a row produces the split-off carry column and the
// zero padding up to the widened row end; a row item yields up to 17 results.
// The configuration port (cfg_we, cfg_index, cfg_data) takes one write per
// cycle, and any write restarts the glyph at row 0, column 0.
// An item goes through the item register and then the result register.
// Results leave at one per cycle unless the receiver stalls, so an item with n
// results holds the input until its last is emitted, and single-result items
// are taken every cycle. On a receiver stall the result register holds and
// the sequencer waits; one item may still be taken meanwhile.
// Reset clears the channels and sets width 1, height 1 and italic off.
module glyph_italic_shear_rasterizer #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gisr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [gisr_pkg::DIM_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   coverage,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   pixel_value,
	output logic [6:0]                   out_column,
	output logic [5:0]                   out_row,
	output logic                         row_end,
	output logic                         glyph_end
);

	gisr_pkg::desc_t desc;
	logic            accept;

	gisr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coverage (coverage),
		.accept   (accept),
		.desc     (desc)
	);

	gisr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (desc),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accept     (accept),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_value(pixel_value),
		.out_column (out_column),
		.out_row    (out_row),
		.row_end    (row_end),
		.glyph_end  (glyph_end)
	);

endmodule

FILE: rtl/gisr_checker.sv
// Port-level checker for the glyph italic shear rasterizer and its bind.
module gisr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_value,
	input logic [6:0] out_column,
	input logic       row_end,
	input logic       glyph_end
);

	logic       seen_q;
	logic       prev_end_q;
	logic [6:0] prev_col_q;
	logic       out_take;

	assign out_take = out_valid && !out_stall;

	// Tracks the last result taken since reset or the last configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			prev_end_q <= 1'b0;
			prev_col_q <= 7'd0;
		end else if (cfg_we) begin
			seen_q <= 1'b0;
		end else if (out_take) begin
			seen_q <= 1'b1;
			prev_end_q <= row_end;
			prev_col_q <= out_column;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(out_column))
		else $error("stalled result changed");

	a_glyph_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_end |-> row_end)
		else $error("glyph end without row end");

	a_next_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && seen_q && !prev_end_q |-> out_column == prev_col_q + 7'd1)
		else $error("destination column skipped or repeated");

	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && (!seen_q || prev_end_q) |-> out_column == 7'd0)
		else $error("destination row does not start at column zero");

endmodule

bind glyph_italic_shear_rasterizer gisr_checker u_gisr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_value(pixel_value),
	.out_column (out_column),
	.row_end    (row_end),
	.glyph_end  (glyph_end)
);
